FILE: hdl/vlti_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlti_pkg
// Shared types, constants and the sequencer program for the video line
// timing and line interrupt block.
// ----------------------------------------------------------------------------
package vlti_pkg;

  // default display geometry (NTSC)
  localparam int PIXELS_PER_LINE_DEF = 342;
  localparam int LINES_PER_FRAME_DEF = 262;
  localparam int ACTIVE_LINES_DEF    = 192;

  // field widths
  localparam int FUNC_W   = 2;
  localparam int PIX_W    = 12;
  localparam int COUNT_W  = 9;
  localparam int RELOAD_W = 8;
  // lines stepped by one item: at most 4095 / 342 + 1 = 12 for the default line length
  localparam int LINES_W  = 5;
  localparam int STEP_W   = 4;

  localparam logic [RELOAD_W-1:0] RELOAD_RESET = 8'hFF;

  // item function codes
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLR_LINE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLR_FRAME = 2'd2;

  // program addresses
  localparam logic [STEP_W-1:0] S_ACCEPT = 4'd0;
  localparam logic [STEP_W-1:0] S_CLEAR  = 4'd1;
  localparam logic [STEP_W-1:0] S_DIVIDE = 4'd2;
  localparam logic [STEP_W-1:0] S_HADD   = 4'd3;
  localparam logic [STEP_W-1:0] S_HWRAP  = 4'd4;
  localparam logic [STEP_W-1:0] S_TEST   = 4'd5;
  localparam logic [STEP_W-1:0] S_LINE   = 4'd6;
  localparam logic [STEP_W-1:0] S_DONE   = 4'd7;
  localparam logic [STEP_W-1:0] S_STATUS = 4'd8;
  localparam logic [STEP_W-1:0] S_WRAP   = 4'd9;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [PIX_W-1:0]  pixel_count;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] line_number;
    logic [COUNT_W-1:0] h_position;
    logic               line_advanced;
    logic               line_irq;
    logic               frame_flag;
    logic               frame_start;
    logic               last;
  } out_item_t;

  // datapath operations
  typedef enum logic [2:0] {
    OP_NOP,
    OP_LOAD,
    OP_CLEAR,
    OP_DIVIDE,
    OP_HADD,
    OP_HWRAP,
    OP_LINE,
    OP_STATUS
  } op_e;

  // jump conditions
  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_ITEM,
    COND_NOT_ADV,
    COND_REM_GE,
    COND_LINES_ZERO,
    COND_LINE_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e               op;
    cond_e             cond;
    logic [STEP_W-1:0] target;
  } cw_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic no_item;
    logic not_adv;
    logic rem_ge;
    logic lines_zero;
    logic line_more;
    logic out_busy;
  } cond_t;

  // control store: taken jump goes to target, otherwise the next step
  function automatic cw_t micro_rom(input logic [STEP_W-1:0] step);
    cw_t cw;
    case (step)
      S_ACCEPT: cw = '{op: OP_LOAD,   cond: COND_NO_ITEM,    target: S_ACCEPT};
      S_CLEAR:  cw = '{op: OP_CLEAR,  cond: COND_NOT_ADV,    target: S_STATUS};
      S_DIVIDE: cw = '{op: OP_DIVIDE, cond: COND_REM_GE,     target: S_DIVIDE};
      S_HADD:   cw = '{op: OP_HADD,   cond: COND_NEVER,      target: S_ACCEPT};
      S_HWRAP:  cw = '{op: OP_HWRAP,  cond: COND_NEVER,      target: S_ACCEPT};
      S_TEST:   cw = '{op: OP_NOP,    cond: COND_LINES_ZERO, target: S_STATUS};
      S_LINE:   cw = '{op: OP_LINE,   cond: COND_LINE_MORE,  target: S_LINE};
      S_DONE:   cw = '{op: OP_NOP,    cond: COND_ALWAYS,     target: S_ACCEPT};
      S_STATUS: cw = '{op: OP_STATUS, cond: COND_OUT_BUSY,   target: S_STATUS};
      S_WRAP:   cw = '{op: OP_NOP,    cond: COND_ALWAYS,     target: S_ACCEPT};
      default:  cw = '{op: OP_NOP,    cond: COND_ALWAYS,     target: S_ACCEPT};
    endcase
    return cw;
  endfunction

endpackage

FILE: hdl/vlti_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlti_seq
// Step counter and control store; picks the next step from the jump
// condition of the current control word.
// ----------------------------------------------------------------------------
module vlti_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  vlti_pkg::cond_t cond_i,
  output vlti_pkg::cw_t cw_o
);

  logic [vlti_pkg::STEP_W-1:0] step_q;
  logic [vlti_pkg::STEP_W-1:0] step_d;
  vlti_pkg::cw_t               cw;
  logic                        taken;

  // control word fetch
  assign cw   = vlti_pkg::micro_rom(step_q);
  assign cw_o = cw;

  // condition select and next step
  always_comb begin
    case (cw.cond)
      vlti_pkg::COND_NEVER:      taken = 1'b0;
      vlti_pkg::COND_ALWAYS:     taken = 1'b1;
      vlti_pkg::COND_NO_ITEM:    taken = cond_i.no_item;
      vlti_pkg::COND_NOT_ADV:    taken = cond_i.not_adv;
      vlti_pkg::COND_REM_GE:     taken = cond_i.rem_ge;
      vlti_pkg::COND_LINES_ZERO: taken = cond_i.lines_zero;
      vlti_pkg::COND_LINE_MORE:  taken = cond_i.line_more;
      vlti_pkg::COND_OUT_BUSY:   taken = cond_i.out_busy;
      default:                   taken = 1'b1;
    endcase
    step_d = taken ? cw.target : step_q + vlti_pkg::STEP_W'(1);
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= vlti_pkg::S_ACCEPT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule

FILE: hdl/vlti_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vlti_dp
// Counters, flags, reload register, divide remainder and result register,
// driven one operation per cycle by the sequencer.
// ----------------------------------------------------------------------------
module vlti_dp #(
  parameter int PIXELS_PER_LINE = vlti_pkg::PIXELS_PER_LINE_DEF,
  parameter int LINES_PER_FRAME = vlti_pkg::LINES_PER_FRAME_DEF,
  parameter int ACTIVE_LINES    = vlti_pkg::ACTIVE_LINES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  vlti_pkg::cw_t                     cw_i,
  output vlti_pkg::cond_t                   cond_o,
  input  logic                              in_valid_i,
  input  vlti_pkg::in_item_t                in_item_i,
  input  logic                              cfg_we_i,
  input  logic [vlti_pkg::RELOAD_W-1:0]     cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output vlti_pkg::out_item_t               out_item_o
);

  localparam int CW = vlti_pkg::COUNT_W;
  localparam int PW = vlti_pkg::PIX_W;
  localparam int LW = vlti_pkg::LINES_W;
  localparam int RW = vlti_pkg::RELOAD_W;

  localparam logic [PW-1:0] PPL_R  = PW'(PIXELS_PER_LINE);
  localparam logic [CW-1:0] LPF_V  = CW'(LINES_PER_FRAME);
  localparam logic [CW-1:0] ACT_V  = CW'(ACTIVE_LINES);
  localparam logic [CW-1:0] VBL_V  = CW'(ACTIVE_LINES + 1);

  // display state
  logic [CW-1:0] h_q, h_d;
  logic [CW-1:0] v_q, v_d;
  logic [RW-1:0] ldc_q, ldc_d;
  logic [RW-1:0] latch_q, latch_d;
  logic [RW-1:0] reload_q;
  logic          irq_q, irq_d;
  logic          frame_q, frame_d;

  // per-item working registers
  logic [vlti_pkg::FUNC_W-1:0] func_q, func_d;
  logic [PW-1:0]               rem_q, rem_d;
  logic [LW-1:0]               lines_q, lines_d;

  // result register
  logic                 out_valid_q, out_valid_d;
  vlti_pkg::out_item_t  out_q, out_d;

  logic          rem_ge;
  logic          out_busy;
  logic [CW-1:0] v_inc;
  logic [RW-1:0] ldc_dec;

  assign rem_ge   = rem_q >= PPL_R;
  assign out_busy = out_valid_q && out_stall_i;
  assign v_inc    = v_q + CW'(1);
  assign ldc_dec  = ldc_q - RW'(1);

  // status for the sequencer
  always_comb begin
    cond_o.no_item    = !in_valid_i;
    cond_o.not_adv    = (func_q != vlti_pkg::FUNC_ADVANCE) || (rem_q == '0);
    cond_o.rem_ge     = rem_ge;
    cond_o.lines_zero = lines_q == '0;
    cond_o.line_more  = out_busy || (lines_q != LW'(1));
    cond_o.out_busy   = out_busy;
  end

  // operation decode
  always_comb begin
    h_d         = h_q;
    v_d         = v_q;
    ldc_d       = ldc_q;
    latch_d     = latch_q;
    irq_d       = irq_q;
    frame_d     = frame_q;
    func_d      = func_q;
    rem_d       = rem_q;
    lines_d     = lines_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;

    case (cw_i.op)
      vlti_pkg::OP_LOAD: begin
        if (in_valid_i) begin
          func_d  = in_item_i.func;
          rem_d   = in_item_i.pixel_count;
          lines_d = '0;
        end
      end
      vlti_pkg::OP_CLEAR: begin
        if (func_q == vlti_pkg::FUNC_CLR_LINE) begin
          irq_d = 1'b0;
        end
        if (func_q == vlti_pkg::FUNC_CLR_FRAME) begin
          frame_d = 1'b0;
        end
      end
      // whole lines by repeated subtraction
      vlti_pkg::OP_DIVIDE: begin
        if (rem_ge) begin
          rem_d   = rem_q - PPL_R;
          lines_d = lines_q + LW'(1);
        end
      end
      vlti_pkg::OP_HADD: begin
        rem_d = rem_q + PW'(h_q);
      end
      // carry of the horizontal counter into one more line
      vlti_pkg::OP_HWRAP: begin
        if (rem_ge) begin
          h_d     = CW'(rem_q - PPL_R);
          lines_d = lines_q + LW'(1);
        end else begin
          h_d = CW'(rem_q);
        end
      end
      // one line step, one result
      vlti_pkg::OP_LINE: begin
        if (!out_busy) begin
          out_d.frame_start = 1'b0;
          if (v_inc <= ACT_V) begin
            if (ldc_q == '0) begin
              ldc_d = latch_q;
              irq_d = 1'b1;
            end else begin
              ldc_d = ldc_dec;
            end
          end else begin
            latch_d = reload_q;
            ldc_d   = reload_q;
          end
          if (v_inc == VBL_V) begin
            frame_d           = 1'b1;
            out_d.frame_start = 1'b1;
          end
          v_d                 = (v_inc >= LPF_V) ? '0 : v_inc;
          lines_d             = lines_q - LW'(1);
          out_d.line_number   = v_d;
          out_d.h_position    = h_q;
          out_d.line_advanced = 1'b1;
          out_d.line_irq      = irq_d;
          out_d.frame_flag    = frame_d;
          out_d.last          = lines_q == LW'(1);
          out_valid_d         = 1'b1;
        end
      end
      vlti_pkg::OP_STATUS: begin
        if (!out_busy) begin
          out_d.line_number   = v_q;
          out_d.h_position    = h_q;
          out_d.line_advanced = 1'b0;
          out_d.line_irq      = irq_q;
          out_d.frame_flag    = frame_q;
          out_d.frame_start   = 1'b0;
          out_d.last          = 1'b1;
          out_valid_d         = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // display state and control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q         <= '0;
      v_q         <= '0;
      ldc_q       <= '0;
      latch_q     <= '0;
      irq_q       <= 1'b0;
      frame_q     <= 1'b0;
      reload_q    <= vlti_pkg::RELOAD_RESET;
      out_valid_q <= 1'b0;
    end else begin
      h_q         <= h_d;
      v_q         <= v_d;
      ldc_q       <= ldc_d;
      latch_q     <= latch_d;
      irq_q       <= irq_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        reload_q <= cfg_data_i;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk_i) begin
    func_q  <= func_d;
    rem_q   <= rem_d;
    lines_q <= lines_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef ASSERT_OFF
  a_h_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    h_q < CW'(PIXELS_PER_LINE))
    else $error("horizontal counter out of range");

  a_v_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q < LPF_V)
    else $error("vertical counter out of range");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.line_advanced |-> out_q.last && !out_q.frame_start)
    else $error("status result not marked last");

  a_line_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cw_i.op == vlti_pkg::OP_LINE |-> lines_q != '0)
    else $error("line step with no lines pending");
`endif

endmodule

FILE: hdl/video_line_timing_interrupt_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// video_line_timing_interrupt_top
// Video line timing with line interrupt counter.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o / in_item_i): an item with func
// advance adds pixel_count pixel clocks; clear-line and clear-frame items
// drop the line interrupt flag or the frame flag. Output channel
// (out_valid_o / out_stall_i / out_item_o): one result per line stepped,
// or one status result when no line is stepped; last marks the final one.
// cfg_we_i / cfg_data_i write the line interrupt reload value.
// One item is worked at a time. A clear item, an unused code or a zero
// count gives its status result; the next item is taken after the status
// and wrap steps. An advance divides pixel_count by the pixels per line,
// adds the remainder to the horizontal position, carries a wrap into one
// more line, then gives one result per line stepped at one per cycle
// while the receiver does not stall, and the next item is taken after the
// done step; an advance that steps no line gives a status result. The
// whole line count comes from a one-subtract-per-cycle loop. Results
// leave through a register, so a stalled receiver holds the sequencer at
// the current line or status step only.
// Reset clears all display counters and flags and sets the reload value to 0xFF.
// ----------------------------------------------------------------------------
module video_line_timing_interrupt_top #(
  parameter int PIXELS_PER_LINE = vlti_pkg::PIXELS_PER_LINE_DEF,
  parameter int LINES_PER_FRAME = vlti_pkg::LINES_PER_FRAME_DEF,
  parameter int ACTIVE_LINES    = vlti_pkg::ACTIVE_LINES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  vlti_pkg::in_item_t            in_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output vlti_pkg::out_item_t           out_item_o,
  input  logic                          cfg_we_i,
  input  logic [vlti_pkg::RELOAD_W-1:0] cfg_data_i
);

  vlti_pkg::cw_t   cw;
  vlti_pkg::cond_t cond;

  // items are taken only at the accept step
  assign in_stall_o = cw.op != vlti_pkg::OP_LOAD;

  // sequencer
  vlti_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cond_i (cond),
    .cw_o   (cw)
  );

  // datapath
  vlti_dp #(
    .PIXELS_PER_LINE (PIXELS_PER_LINE),
    .LINES_PER_FRAME (LINES_PER_FRAME),
    .ACTIVE_LINES    (ACTIVE_LINES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cw_i        (cw),
    .cond_o      (cond),
    .in_valid_i  (in_valid_i),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule
